// File: rtl/msmc_pkg.sv
// Shared types and codes for the max-tracking stack.
// Request/result payload structs, request and status codes, datapath command struct.
`timescale 1ns / 1ps

package msmc_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int DEPTH_DEFAULT = 256;
  localparam int OCC_W         = 9;

  // request codes; the unused code behaves as a peek
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] push_value;
  } msmc_in_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] top_value;
    logic signed [DATA_WIDTH-1:0] max_value;
    logic                         is_empty;
    logic [OCC_W-1:0]             occupancy;
  } msmc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the request
    logic exec;    // update stacks, issue refill reads
    logic finish;  // take refill data, build the result
  } msmc_cmd_t;

endpackage

// File: rtl/max_stack_max_count_core.sv
// Top level of the max-tracking LIFO stack.
// Depends on msmc_pkg, msmc_ctrl, msmc_datapath (and msmc_ram below it).
//
// Usage:
//   Request channel: drive in_req (req_type, push_value) and raise start. The
//   request is taken at a rising edge where start is high and busy is low.
//   req_type: push, pop, or peek (the unused code also peeks).
//   Result channel: out_res is valid for exactly one cycle while out_strobe is
//   high. The receiver cannot stall; it must take the result in that cycle.
// Timing:
//   The request is registered when taken; the sequencer runs execute, then finish,
//   and the result is registered and strobed. busy is high through both, so no new
//   request is taken before the last is through. The cost is set by the RAM read
//   latency: the cached top value and top (max, count) pair are refilled from the
//   value RAM and pair RAM in the cycle after a pop issues the read. A new request
//   may be taken in the same cycle the previous result is strobed.
// Reset:
//   Synchronous, active-low rst_n empties both stacks (counts to zero) and
//   returns the sequencer to idle. RAM contents are not cleared; only written
//   entries are ever read back.
`timescale 1ns / 1ps

module max_stack_max_count_core
  import msmc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  msmc_in_t  in_req,
  output logic      out_strobe,
  output msmc_out_t out_res
);

  msmc_cmd_t cmd;

  // sequencer: idle -> execute -> finish
  msmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  // stacks, cached tops, result register
  msmc_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request accept");

  // the result strobe follows the accept once execute and finish are done
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result not strobed at fixed latency");

  // a result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

  // an empty stack reports no maximum and cannot have refused a push
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.is_empty) |->
      (out_res.max_value == '0 && out_res.status != STAT_FULL))
    else $error("inconsistent empty result");

endmodule

// File: rtl/msmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/msmc_ctrl.sv
// Sequencer for the max-tracking stack: idle, execute, finish.
// Depends on msmc_pkg.
`timescale 1ns / 1ps

module msmc_ctrl
  import msmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output msmc_cmd_t cmd,
  output logic      out_strobe
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       strobe_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_FIN);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.exec   = (state_r == S_EXEC);
  assign cmd.finish = (state_r == S_FIN);
  assign out_strobe = strobe_r;

endmodule

// File: rtl/msmc_datapath.sv
// Stack datapath: cached top value and top (max, count) pair, two RAMs below them.
// Depends on msmc_pkg and msmc_ram.
`timescale 1ns / 1ps

module msmc_datapath
  import msmc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  msmc_cmd_t cmd,
  input  msmc_in_t  in_req,
  output msmc_out_t out_res
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAIR_W = DATA_WIDTH + CNT_W;

  msmc_in_t req_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, mcnt_r, mcnt_nxt, rep_r, rep_nxt;
  logic [CNT_W-1:0] cnt_m1, cnt_m2, mcnt_m1, mcnt_m2, rep_dec;
  logic signed [DATA_WIDTH-1:0] top_val_r, top_val_nxt, top_max_r, top_max_nxt;
  logic signed [DATA_WIDTH-1:0] res_top_r, res_top_nxt;
  logic [1:0] status_r, status_nxt;
  logic       refill_val_r, refill_val_nxt, refill_pair_r, refill_pair_nxt;
  msmc_out_t  out_r, out_nxt;

  logic                  val_we, pair_we;
  logic [AW-1:0]         val_waddr, val_raddr, pair_waddr, pair_raddr;
  logic [DATA_WIDTH-1:0] val_wdata, val_rdata;
  logic [PAIR_W-1:0]     pair_wdata, pair_rdata;

  logic signed [DATA_WIDTH-1:0] refill_max;
  logic [CNT_W-1:0]             refill_rep;

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign cnt_m2  = cnt_r - CNT_W'(2);
  assign mcnt_m1 = mcnt_r - CNT_W'(1);
  assign mcnt_m2 = mcnt_r - CNT_W'(2);
  assign rep_dec = (rep_r != '0) ? rep_r - CNT_W'(1) : rep_r;

  assign refill_max = $signed(pair_rdata[PAIR_W-1:CNT_W]);
  assign refill_rep = pair_rdata[CNT_W-1:0];

  msmc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  msmc_ram #(.WIDTH(PAIR_W), .DEPTH(DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  // execute and finish steps: the RAMs hold everything below the cached top entries
  always_comb begin
    cnt_nxt         = cnt_r;
    mcnt_nxt        = mcnt_r;
    rep_nxt         = rep_r;
    top_val_nxt     = top_val_r;
    top_max_nxt     = top_max_r;
    res_top_nxt     = res_top_r;
    status_nxt      = status_r;
    refill_val_nxt  = refill_val_r;
    refill_pair_nxt = refill_pair_r;
    val_we          = 1'b0;
    val_waddr       = cnt_m1[AW-1:0];
    val_wdata       = top_val_r;
    val_raddr       = cnt_m2[AW-1:0];
    pair_we         = 1'b0;
    pair_waddr      = mcnt_m1[AW-1:0];
    pair_wdata      = {top_max_r, rep_r};
    pair_raddr      = mcnt_m2[AW-1:0];
    out_nxt         = out_r;

    if (cmd.exec) begin
      refill_val_nxt  = 1'b0;
      refill_pair_nxt = 1'b0;
      status_nxt      = STAT_OK;
      case (req_r.req_type)
        REQ_PUSH: begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            status_nxt  = STAT_FULL;
            res_top_nxt = top_val_r;
          end else begin
            val_we      = (cnt_r != '0);   // bury the old top
            top_val_nxt = req_r.push_value;
            res_top_nxt = req_r.push_value;
            cnt_nxt     = cnt_r + CNT_W'(1);
            if (mcnt_r == '0) begin
              top_max_nxt = req_r.push_value;
              rep_nxt     = CNT_W'(1);
              mcnt_nxt    = CNT_W'(1);
            end else if (req_r.push_value == top_max_r) begin
              rep_nxt = rep_r + CNT_W'(1);
            end else if (req_r.push_value > top_max_r && mcnt_r != CNT_W'(DEPTH)) begin
              pair_we     = 1'b1;             // bury the old pair
              top_max_nxt = req_r.push_value;
              rep_nxt     = CNT_W'(1);
              mcnt_nxt    = mcnt_r + CNT_W'(1);
            end
          end
        end
        REQ_POP: begin
          if (cnt_r == '0) begin
            status_nxt  = STAT_EMPTY;
            res_top_nxt = '0;
          end else begin
            res_top_nxt    = top_val_r;
            cnt_nxt        = cnt_m1;
            refill_val_nxt = (cnt_m1 != '0);
            if (mcnt_r != '0 && top_val_r == top_max_r) begin
              if (rep_dec == '0) begin
                mcnt_nxt        = mcnt_m1;
                refill_pair_nxt = (mcnt_m1 != '0);
              end else begin
                rep_nxt = rep_dec;
              end
            end
            if (cnt_m1 == '0) begin
              mcnt_nxt        = '0;
              refill_pair_nxt = 1'b0;
            end
          end
        end
        default: begin
          // peek, also for the unused code
          if (cnt_r == '0) begin
            status_nxt  = STAT_EMPTY;
            res_top_nxt = '0;
          end else begin
            res_top_nxt = top_val_r;
          end
        end
      endcase
    end

    if (cmd.finish) begin
      if (refill_val_r) begin
        top_val_nxt = $signed(val_rdata);
      end
      if (refill_pair_r) begin
        top_max_nxt = refill_max;
        rep_nxt     = refill_rep;
      end
      out_nxt.status    = status_r;
      out_nxt.top_value = res_top_r;
      out_nxt.max_value = (cnt_r == '0 || mcnt_r == '0) ? '0 : top_max_nxt;
      out_nxt.is_empty  = (cnt_r == '0);
      out_nxt.occupancy = OCC_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      mcnt_r        <= '0;
      refill_val_r  <= 1'b0;
      refill_pair_r <= 1'b0;
    end else begin
      cnt_r         <= cnt_nxt;
      mcnt_r        <= mcnt_nxt;
      refill_val_r  <= refill_val_nxt;
      refill_pair_r <= refill_pair_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    rep_r     <= rep_nxt;
    top_val_r <= top_val_nxt;
    top_max_r <= top_max_nxt;
    res_top_r <= res_top_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  assign out_res = out_r;

endmodule

// File: dv/tb.sv
// Self-checking testbench for max_stack_max_count_core: push/pop/peek traffic
// checked result by result against a behavioral stack model kept in the bench.
// Depends on msmc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import msmc_pkg::*;

  localparam int STACK_DEPTH    = DEPTH_DEFAULT;
  localparam int RANDOM_REQS    = 1850;
  localparam int CALM_TAIL      = 200;   // last random requests go back to back
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request and no result
  localparam int DRAIN_CYCLES   = 12;    // idle time after the last result, to catch stray strobes

  localparam logic [1:0] REQ_SPARE = 2'd3;  // unused code, must behave as peek

  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // directed row: request plus, for the obvious cases, a hand-typed result
  typedef struct packed {
    msmc_in_t  req;
    logic      typed;
    msmc_out_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  msmc_in_t  in_req;
  logic      out_strobe;
  msmc_out_t out_res;

  // bench copy of the stack: values plus (peak, repeat count) pairs
  logic signed [DATA_WIDTH-1:0] val_mem   [STACK_DEPTH];
  int unsigned                  val_depth;
  logic signed [DATA_WIDTH-1:0] peak_mem  [STACK_DEPTH];
  int unsigned                  peak_reps [STACK_DEPTH];
  int unsigned                  peak_depth;

  msmc_out_t expected_results[$];
  dir_row_t  directed[$];

  int mismatches;
  int results_seen;
  int requests_sent;
  int random_sent;
  int full_hits;
  int empty_hits;
  int stall_cycles;

  max_stack_max_count_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stack model. Push equal to the top peak bumps its count, a larger push opens
  // a new pair; popping a value equal to the top peak decrements and drops the
  // pair at zero. Full push and empty pop/peek change nothing.
  // ---------------------------------------------------------------------------
  task automatic stack_model_step(input msmc_in_t r, output msmc_out_t res);
    logic signed [DATA_WIDTH-1:0] v;
    logic signed [DATA_WIDTH-1:0] top;
    logic [1:0]                   st;
    v   = r.push_value;
    st  = STAT_OK;
    top = '0;
    case (r.req_type)
      REQ_PUSH: begin
        if (val_depth >= STACK_DEPTH) begin
          st  = STAT_FULL;
          top = val_mem[val_depth-1];
        end else begin
          val_mem[val_depth] = v;
          val_depth++;
          if (peak_depth == 0) begin
            peak_mem[0]  = v;
            peak_reps[0] = 1;
            peak_depth   = 1;
          end else if (v == peak_mem[peak_depth-1]) begin
            peak_reps[peak_depth-1]++;
          end else if (v > peak_mem[peak_depth-1] && peak_depth < STACK_DEPTH) begin
            peak_mem[peak_depth]  = v;
            peak_reps[peak_depth] = 1;
            peak_depth++;
          end
          top = v;
        end
      end
      REQ_POP: begin
        if (val_depth == 0) begin
          st = STAT_EMPTY;
        end else begin
          val_depth--;
          top = val_mem[val_depth];
          if (peak_depth > 0 && top == peak_mem[peak_depth-1]) begin
            if (peak_reps[peak_depth-1] > 0) peak_reps[peak_depth-1]--;
            if (peak_reps[peak_depth-1] == 0) peak_depth--;
          end
          if (val_depth == 0) peak_depth = 0;
        end
      end
      default: begin
        // peek, and the spare code
        if (val_depth == 0) st = STAT_EMPTY;
        else top = val_mem[val_depth-1];
      end
    endcase
    res.status    = st;
    res.top_value = top;
    res.max_value = (val_depth == 0 || peak_depth == 0) ? '0 : peak_mem[peak_depth-1];
    res.is_empty  = (val_depth == 0);
    res.occupancy = OCC_W'(val_depth);
  endtask

  function automatic dir_row_t row_pred(logic [1:0] code, logic signed [DATA_WIDTH-1:0] v);
    dir_row_t r;
    r                = '0;
    r.req.req_type   = code;
    r.req.push_value = v;
    return r;
  endfunction

  function automatic dir_row_t row_fixed(logic [1:0] code, logic signed [DATA_WIDTH-1:0] v,
                                         logic [1:0] st, logic signed [DATA_WIDTH-1:0] top,
                                         logic signed [DATA_WIDTH-1:0] mx, logic emp,
                                         logic [OCC_W-1:0] occ);
    dir_row_t r;
    r                = row_pred(code, v);
    r.typed          = 1'b1;
    r.want.status    = st;
    r.want.top_value = top;
    r.want.max_value = mx;
    r.want.is_empty  = emp;
    r.want.occupancy = occ;
    return r;
  endfunction

  // Value mix: a narrow pool so equal peaks repeat often, the extremes, and
  // fully random words so every bit toggles.
  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return DATA_WIDTH'($signed($urandom_range(0, 6)) - 3);
    if (sel < 55) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        4: return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return REQ_PUSH;
    if (sel < 85) return REQ_POP;
    if (sel < 95) return REQ_PEEK;
    return REQ_SPARE;
  endfunction

  // Sender idling: an idle gap before about one request in four, none in quiet phases or the tail.
  function automatic int pick_gap(bit quiet);
    if (quiet || random_sent >= RANDOM_REQS - CALM_TAIL) return 0;
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
  endfunction

  // Called at a rising edge. start stays high across back-to-back requests so
  // it never sees two assignments in one step.
  task automatic send_request(input msmc_in_t r, input logic typed, input msmc_out_t want,
                              input int gap);
    msmc_out_t predicted;
    msmc_in_t  junk;
    if (gap > 0) begin
      junk.req_type   = 2'($urandom);
      junk.push_value = $urandom;
      start  <= 1'b0;
      in_req <= junk;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    // busy read here is its pre-edge value, so this edge takes the request
    do @(posedge clk); while (busy !== 1'b0);
    stack_model_step(r, predicted);
    if (predicted.status == STAT_FULL) full_hits++;
    if (predicted.status == STAT_EMPTY) empty_hits++;
    expected_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic send_random(input logic [1:0] code, input bit quiet);
    msmc_in_t r;
    r.req_type   = code;
    r.push_value = pick_value();
    send_request(r, 1'b0, '0, pick_gap(quiet));
    random_sent++;
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_WIDTH-1:0] got,
                                 input logic [DATA_WIDTH-1:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. The receiver cannot stall, so every strobe is
  // taken and compared against the oldest outstanding expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    msmc_out_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, top_value", out_res.top_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_res.status !== want.status)
          report_mismatch("status", DATA_WIDTH'(out_res.status), DATA_WIDTH'(want.status));
        if (out_res.top_value !== want.top_value)
          report_mismatch("top_value", out_res.top_value, want.top_value);
        if (out_res.max_value !== want.max_value)
          report_mismatch("max_value", out_res.max_value, want.max_value);
        if (out_res.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_WIDTH'(out_res.is_empty),
                          DATA_WIDTH'(want.is_empty));
        if (out_res.occupancy !== want.occupancy)
          report_mismatch("occupancy", DATA_WIDTH'(out_res.occupancy),
                          DATA_WIDTH'(want.occupancy));
      end
      results_seen++;
    end

    if (!rst_n || (start && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int  mode;
    int  extra;
    int  len;
    bit  quiet;

    start         = 1'b0;
    in_req        = '0;
    rst_n         = 1'b0;
    val_depth     = 0;
    peak_depth    = 0;
    mismatches    = 0;
    results_seen  = 0;
    requests_sent = 0;
    random_sent   = 0;
    full_hits     = 0;
    empty_hits    = 0;
    stall_cycles  = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty stack first, extremes, repeated peaks, peak rollback.
    directed = '{
      row_fixed(REQ_POP,   '0, STAT_EMPTY, '0, '0, 1'b1, 9'd0),
      row_fixed(REQ_PEEK,  '0, STAT_EMPTY, '0, '0, 1'b1, 9'd0),
      row_fixed(REQ_SPARE, VAL_MAX, STAT_EMPTY, '0, '0, 1'b1, 9'd0),
      row_fixed(REQ_PUSH,  VAL_MIN, STAT_OK, VAL_MIN, VAL_MIN, 1'b0, 9'd1),
      row_pred (REQ_PUSH,  VAL_MIN),
      row_fixed(REQ_PUSH,  VAL_MAX, STAT_OK, VAL_MAX, VAL_MAX, 1'b0, 9'd3),
      row_pred (REQ_PUSH,  VAL_MAX),   // equal peak: count goes to 2
      row_pred (REQ_PUSH,  '1),        // smaller: pairs untouched
      row_pred (REQ_PUSH,  '0),
      row_pred (REQ_SPARE, 32'h1234_5678),
      row_pred (REQ_PEEK,  '0),
      row_pred (REQ_POP,   '0),
      row_pred (REQ_POP,   '0),
      row_pred (REQ_POP,   '0),        // first MAX off, peak still MAX
      row_pred (REQ_POP,   '0),        // second MAX off, peak back to MIN
      row_pred (REQ_PUSH,  32'sd1),
      row_pred (REQ_PUSH,  32'sd1),
      row_pred (REQ_POP,   '0),
      row_pred (REQ_POP,   '0),
      row_pred (REQ_POP,   '0),
      row_fixed(REQ_POP,   '0, STAT_OK, VAL_MIN, '0, 1'b1, 9'd0),
      row_fixed(REQ_POP,   '0, STAT_EMPTY, '0, '0, 1'b1, 9'd0),
      row_pred (REQ_PUSH,  32'h5555_5555),
      row_pred (REQ_PUSH,  32'hAAAA_AAAA),
      row_pred (REQ_PEEK,  '0)
    };
    foreach (directed[i])
      send_request(directed[i].req, directed[i].typed, directed[i].want, pick_gap(1'b0));

    // Random phases: fill to full and push past it, drain to empty and pop or peek past
    // it, or a mixed walk. Some phases run with no sender idling at all.
    while (random_sent < RANDOM_REQS) begin
      mode  = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 2) == 0);
      if (mode < 2) begin
        while (val_depth < STACK_DEPTH) send_random(REQ_PUSH, quiet);
        extra = $urandom_range(1, 4);
        repeat (extra) send_random(REQ_PUSH, quiet);
        send_random(REQ_PEEK, quiet);
      end else if (mode < 4) begin
        while (val_depth > 0) send_random(REQ_POP, quiet);
        extra = $urandom_range(1, 3);
        repeat (extra) send_random(($urandom_range(0, 1) == 0) ? REQ_POP : REQ_PEEK, quiet);
      end else begin
        len = $urandom_range(20, 80);
        repeat (len) send_random(pick_code(), quiet);
      end
    end
    start <= 1'b0;

    // wait out the results still in flight, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d random), checked %0d results", requests_sent,
             random_sent, results_seen);
    $display("Full-stack pushes: %0d, empty pops/peeks: %0d, mismatches: %0d", full_hits,
             empty_hits, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
